@@ design/assert_macros.svh @@
// Assertion helpers, included by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/uwr_pkg.sv @@
package uwr_pkg;

   localparam int CFG_DIM_W = 13;
   localparam int PITCH_W   = 14;
   localparam int ADDR_W    = 25;
   localparam int PIX_W     = 24;
   localparam int SCALE_W   = 4;   // holds 0..15, scale uses 0..8
   localparam int CNT_W     = 3;   // holds 0..7
   localparam int PROD_W    = CFG_DIM_W + SCALE_W;
   localparam int CSR_ADDR_W = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PANEL_WIDTH  = 3'd2;
   localparam logic [2:0] REG_PANEL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_PITCH_WORDS  = 3'd4;
   localparam logic [2:0] REG_ORDER_BGRA   = 3'd5;

   typedef struct packed {
      logic [31:0] src_pixel;
      logic [11:0] src_col;
      logic [11:0] src_row;
   } uwr_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dest_addr;
      logic [PIX_W-1:0]  out_pixel;
      logic              fault;
      logic              last;
   } uwr_rsp_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] frame_width;
      logic [CFG_DIM_W-1:0] frame_height;
      logic [CFG_DIM_W-1:0] panel_width;
      logic [CFG_DIM_W-1:0] panel_height;
      logic [PITCH_W-1:0]   pitch_words;
      logic                 order_is_bgra;
   } uwr_cfg_type;

   // one classified request, ready for the writer
   typedef struct packed {
      logic              fault;
      logic [SCALE_W-1:0] scale;
      logic [ADDR_W-1:0] start_addr;
      logic [PIX_W-1:0]  pixel;
   } uwr_job_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SCALE,
      FR_BASE,
      FR_ADDR
   } uwr_front_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } uwr_back_state_type;

endpackage

@@ design/uwr_front.sv @@
module uwr_front
   import uwr_pkg::*;
#(
   parameter int MAX_DIM   = 4096,
   parameter int MAX_SCALE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  uwr_req_type req_data,
   input  uwr_cfg_type cfg,
   input  logic        q_full,
   output logic        q_push,
   output uwr_job_type q_job
);

   localparam logic [CFG_DIM_W:0] DIM_LIMIT = (CFG_DIM_W + 1)'(MAX_DIM);

   uwr_front_state_type state_ff, state_in;
   logic accept;

   uwr_req_type         req_ff;
   logic                fault_ff, fault_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [PROD_W-1:0]   fws_ff, fws_in, fhs_ff, fhs_in;
   logic [PROD_W-1:0]   base_c_ff, base_c_in, base_r_ff, base_r_in;
   logic [PIX_W-1:0]    pixel_ff, pixel_in;

   logic [PROD_W-1:0] prod_w, prod_h;
   logic              dim_bad, coord_bad;
   logic [PROD_W-1:0] x0, y0;
   logic [PROD_W+PITCH_W-1:0] row_prod;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE:  if (start && !q_full) state_in = FR_SCALE;
         FR_SCALE: state_in = FR_BASE;
         FR_BASE:  state_in = FR_ADDR;
         FR_ADDR:  state_in = FR_IDLE;
         default:  state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      accept = (state_ff == FR_IDLE) && start && !q_full;
      busy   = (state_ff != FR_IDLE) || q_full;
      q_push = (state_ff == FR_ADDR);
   end

   // scale search: fit is a prefix of 1..MAX_SCALE, keep the last hit
   always_comb begin
      scale_in = '0;
      fws_in   = '0;
      fhs_in   = '0;
      prod_w   = '0;
      prod_h   = '0;
      for (int s = 1; s <= MAX_SCALE; s++) begin
         prod_w = PROD_W'(cfg.frame_width) * PROD_W'(s);
         prod_h = PROD_W'(cfg.frame_height) * PROD_W'(s);
         if (prod_w <= PROD_W'(cfg.panel_width) && prod_h <= PROD_W'(cfg.panel_height)) begin
            scale_in = SCALE_W'(s);
            fws_in   = prod_w;
            fhs_in   = prod_h;
         end
      end
      dim_bad = (cfg.frame_width == '0) || (cfg.frame_height == '0) ||
                ({1'b0, cfg.frame_width}  > DIM_LIMIT) ||
                ({1'b0, cfg.frame_height} > DIM_LIMIT) ||
                ({1'b0, cfg.panel_width}  > DIM_LIMIT) ||
                ({1'b0, cfg.panel_height} > DIM_LIMIT);
      coord_bad = ({1'b0, req_ff.src_col} >= cfg.frame_width) ||
                  ({1'b0, req_ff.src_row} >= cfg.frame_height);
      fault_in = dim_bad || (scale_in == '0) || coord_bad;
   end

   // centering offsets and block origin
   always_comb begin
      x0 = (PROD_W'(cfg.panel_width)  - fws_ff) >> 1;
      y0 = (PROD_W'(cfg.panel_height) - fhs_ff) >> 1;
      base_c_in = x0 + PROD_W'(req_ff.src_col) * PROD_W'(scale_ff);
      base_r_in = y0 + PROD_W'(req_ff.src_row) * PROD_W'(scale_ff);
      if (cfg.order_is_bgra)
         pixel_in = req_ff.src_pixel[23:0];
      else
         pixel_in = {req_ff.src_pixel[7:0], req_ff.src_pixel[15:8], req_ff.src_pixel[23:16]};
   end

   always_comb begin
      row_prod = (PROD_W + PITCH_W)'(base_r_ff) * (PROD_W + PITCH_W)'(cfg.pitch_words);
      q_job.fault = fault_ff;
      q_job.scale = scale_ff;
      if (fault_ff) begin
         q_job.start_addr = '0;
         q_job.pixel      = '0;
      end else begin
         q_job.start_addr = row_prod[ADDR_W-1:0] + ADDR_W'(base_c_ff);
         q_job.pixel      = pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == FR_SCALE) begin
         scale_ff <= scale_in;
         fault_ff <= fault_in;
         fws_ff   <= fws_in;
         fhs_ff   <= fhs_in;
      end
      if (state_ff == FR_BASE) begin
         base_c_ff <= base_c_in;
         base_r_ff <= base_r_in;
         pixel_ff  <= pixel_in;
      end
   end

endmodule

@@ design/uwr_queue.sv @@
module uwr_queue
   import uwr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  uwr_job_type push_job,
   input  logic        pop,
   output uwr_job_type head,
   output logic        empty,
   output logic        full
);

   uwr_job_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/uwr_back.sv @@
module uwr_back
   import uwr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  uwr_job_type        q_head,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic [PITCH_W-1:0] pitch_words,
   output logic               rsp_strobe,
   output uwr_rsp_type        rsp_data
);

   uwr_back_state_type state_ff, state_in;
   logic emit, is_last;

   logic              fault_ff;
   logic [CNT_W-1:0]  sm1_ff, dx_ff, dy_ff;
   logic [ADDR_W-1:0] row_addr_ff;
   logic [PIX_W-1:0]  pixel_ff;
   logic              rsp_strobe_ff;
   uwr_rsp_type       rsp_data_ff;

   assign is_last = fault_ff || (dx_ff == sm1_ff && dy_ff == sm1_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (!q_empty) state_in = BK_RUN;
         BK_RUN:  if (is_last)  state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = (state_ff == BK_IDLE) && !q_empty;
      emit  = (state_ff == BK_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         fault_ff    <= q_head.fault;
         sm1_ff      <= CNT_W'(q_head.scale - 1'b1);
         dx_ff       <= '0;
         dy_ff       <= '0;
         row_addr_ff <= q_head.start_addr;
         pixel_ff    <= q_head.pixel;
      end else if (emit) begin
         if (dx_ff == sm1_ff) begin
            dx_ff       <= '0;
            dy_ff       <= dy_ff + 1'b1;
            row_addr_ff <= row_addr_ff + ADDR_W'(pitch_words);
         end else begin
            dx_ff <= dx_ff + 1'b1;
         end
      end
      if (emit) begin
         rsp_data_ff.dest_addr <= row_addr_ff + ADDR_W'(dx_ff);
         rsp_data_ff.out_pixel <= pixel_ff;
         rsp_data_ff.fault     <= fault_ff;
         rsp_data_ff.last      <= is_last;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ design/integer_upscale_center_writer_core.sv @@
// Integer upscale writer. Each request carries one source pixel with its
// column and row; the block answers with scale*scale destination writes
// (scale = largest whole factor fitting the frame into the panel, capped
// at MAX_SCALE, frame centered), row by row, last set on the final one.
// A bad setup or an out-of-frame coordinate gives one result with fault
// and last set and zero address and pixel. Results are one-cycle strobes
// on rsp_strobe and cannot be held off by the receiver. The front end
// takes a request through capture, scale search, origin and address
// multiply before it accepts the next; the back end fetches a job, then
// gives one result per cycle; a two-entry job queue sits between them.
// busy is high while the front end works or the queue is full.
// Configuration must be written only while no request is outstanding.
`include "assert_macros.svh"

module integer_upscale_center_writer_core
   import uwr_pkg::*;
#(
   parameter int MAX_DIM   = 4096,
   parameter int MAX_SCALE = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  uwr_req_type           req_data,
   // result channel
   output logic                  rsp_strobe,
   output uwr_rsp_type           rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   uwr_cfg_type cfg_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   logic        q_push, q_pop, q_empty, q_full;
   uwr_job_type q_job, q_head;

   logic        rsp_zero_last;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // register file; unlisted indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= CFG_DIM_W'(1);
         cfg_ff.frame_height  <= CFG_DIM_W'(1);
         cfg_ff.panel_width   <= CFG_DIM_W'(1);
         cfg_ff.panel_height  <= CFG_DIM_W'(1);
         cfg_ff.pitch_words   <= PITCH_W'(1);
         cfg_ff.order_is_bgra <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_WIDTH:  cfg_ff.frame_width   <= csr_pwdata[CFG_DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height  <= csr_pwdata[CFG_DIM_W-1:0];
            REG_PANEL_WIDTH:  cfg_ff.panel_width   <= csr_pwdata[CFG_DIM_W-1:0];
            REG_PANEL_HEIGHT: cfg_ff.panel_height  <= csr_pwdata[CFG_DIM_W-1:0];
            REG_PITCH_WORDS:  cfg_ff.pitch_words   <= csr_pwdata[PITCH_W-1:0];
            REG_ORDER_BGRA:   cfg_ff.order_is_bgra <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = 32'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = 32'(cfg_ff.frame_height);
         REG_PANEL_WIDTH:  csr_prdata = 32'(cfg_ff.panel_width);
         REG_PANEL_HEIGHT: csr_prdata = 32'(cfg_ff.panel_height);
         REG_PITCH_WORDS:  csr_prdata = 32'(cfg_ff.pitch_words);
         REG_ORDER_BGRA:   csr_prdata = 32'(cfg_ff.order_is_bgra);
         default:          csr_prdata = '0;
      endcase
   end

   // front end: capture, classify, compute block origin
   uwr_front #(
      .MAX_DIM   (MAX_DIM),
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (q_job)
   );

   // job queue between the two halves
   uwr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back end: walks the scale-by-scale block, one write per cycle
   uwr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .pitch_words (cfg_ff.pitch_words),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   // zeroed final result, the only legal shape of a fault
   assign rsp_zero_last = rsp_data.last && (rsp_data.dest_addr == '0) &&
                          (rsp_data.out_pixel == '0);

   // an accepted request keeps the front end busy next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a fault result is a lone, zeroed, final result
   `ASSERT_IMPLY(a_fault_form, clock, reset, rsp_strobe && rsp_data.fault, rsp_zero_last)
   // the front end never pushes into a full queue
   `ASSERT_IMPLY(a_no_overflow, clock, reset, q_push, !q_full)
   // results of one request come back to back
   `ASSERT_NEXT(a_block_contig, clock, reset, rsp_strobe && !rsp_data.last, rsp_strobe)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import uwr_pkg::*;

   localparam int MAX_DIM     = 4096;
   localparam int MAX_SCALE   = 8;
   localparam int CYCLE_LIMIT = 400000;   // bounds a run of roughly 300 requests

   // Tracks the destination writes each accepted request must produce.
   class block_write_tracker;
      uwr_cfg_type cfg;
      uwr_rsp_type pending_writes[$];
      int          mismatches;

      function new();
         cfg               = '0;
         cfg.frame_width   = 1;
         cfg.frame_height  = 1;
         cfg.panel_width   = 1;
         cfg.panel_height  = 1;
         cfg.pitch_words   = 1;
         cfg.order_is_bgra = 1'b0;
         mismatches        = 0;
      endfunction

      function void report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_FRAME_WIDTH:  cfg.frame_width   = value[CFG_DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg.frame_height  = value[CFG_DIM_W-1:0];
            REG_PANEL_WIDTH:  cfg.panel_width   = value[CFG_DIM_W-1:0];
            REG_PANEL_HEIGHT: cfg.panel_height  = value[CFG_DIM_W-1:0];
            REG_PITCH_WORDS:  cfg.pitch_words   = value[PITCH_W-1:0];
            REG_ORDER_BGRA:   cfg.order_is_bgra = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(logic [2:0] idx);
         case (idx)
            REG_FRAME_WIDTH:  return 32'(cfg.frame_width);
            REG_FRAME_HEIGHT: return 32'(cfg.frame_height);
            REG_PANEL_WIDTH:  return 32'(cfg.panel_width);
            REG_PANEL_HEIGHT: return 32'(cfg.panel_height);
            REG_PITCH_WORDS:  return 32'(cfg.pitch_words);
            REG_ORDER_BGRA:   return 32'(cfg.order_is_bgra);
            default:          return 32'd0;
         endcase
      endfunction

      // Expands one source pixel into its scale x scale block of writes.
      function void note_pixel(uwr_req_type r);
         longint unsigned fw, fh, pw, ph, scale, sy, x0, y0, base_row, base_col;
         longint unsigned dy, dx, full_addr;
         logic [PIX_W-1:0] conv;
         uwr_rsp_type w;
         fw = cfg.frame_width;
         fh = cfg.frame_height;
         pw = cfg.panel_width;
         ph = cfg.panel_height;
         w       = '0;
         w.fault = 1'b1;
         w.last  = 1'b1;
         if (fw == 0 || fh == 0 || fw > MAX_DIM || fh > MAX_DIM ||
             pw > MAX_DIM || ph > MAX_DIM) begin
            pending_writes.push_back(w);
            return;
         end
         scale = pw / fw;
         sy    = ph / fh;
         if (sy < scale) scale = sy;
         if (scale > MAX_SCALE) scale = MAX_SCALE;
         if (scale == 0 || r.src_col >= fw || r.src_row >= fh) begin
            pending_writes.push_back(w);
            return;
         end
         x0 = (pw - fw * scale) / 2;
         y0 = (ph - fh * scale) / 2;
         base_row = y0 + r.src_row * scale;
         base_col = x0 + r.src_col * scale;
         conv = cfg.order_is_bgra ? r.src_pixel[23:0]
                                  : {r.src_pixel[7:0], r.src_pixel[15:8], r.src_pixel[23:16]};
         for (dy = 0; dy < scale; dy++) begin
            for (dx = 0; dx < scale; dx++) begin
               full_addr   = (base_row + dy) * cfg.pitch_words + base_col + dx;
               w.dest_addr = full_addr[ADDR_W-1:0];
               w.out_pixel = conv;
               w.fault     = 1'b0;
               w.last      = (dy == scale - 1) && (dx == scale - 1);
               pending_writes.push_back(w);
            end
         end
      endfunction

      function void check_write(uwr_rsp_type got);
         uwr_rsp_type want;
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("write with none pending: addr %h pixel %h fault %b last %b",
                                      got.dest_addr, got.out_pixel, got.fault, got.last));
            return;
         end
         want = pending_writes.pop_front();
         if (got.dest_addr !== want.dest_addr)
            report_mismatch($sformatf("dest_addr %h, want %h", got.dest_addr, want.dest_addr));
         if (got.out_pixel !== want.out_pixel)
            report_mismatch($sformatf("out_pixel %h, want %h", got.out_pixel, want.out_pixel));
         if (got.fault !== want.fault)
            report_mismatch($sformatf("fault %b, want %b", got.fault, want.fault));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT signals
   // ---------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   uwr_req_type           req_data;
   logic                  rsp_strobe;
   uwr_rsp_type           rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   block_write_tracker tracker;
   int                 cycle_count = 0;

   integer_upscale_center_writer_core #(
      .MAX_DIM   (MAX_DIM),
      .MAX_SCALE (MAX_SCALE)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor: everything is sampled at the rising edge, before the DUT's
   // flops update. Results are checked before the new request is noted, since
   // a result at this edge can only belong to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            tracker.check_write(rsp_data);
         if (start && !busy)
            tracker.note_pixel(req_data);
      end
   end

   // Watchdog: a hung DUT ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. All tasks are entered and left just after a falling edge and
   // change inputs only there, with blocking assignments from one process.
   // ---------------------------------------------------------------------

   function automatic uwr_req_type make_req(logic [31:0] pixel, logic [11:0] col,
                                             logic [11:0] row);
      uwr_req_type r;
      r.src_pixel = pixel;
      r.src_col   = col;
      r.src_row   = row;
      return r;
   endfunction

   // Holds start low while random draws against idle_pct come up idle,
   // then presents the request until busy is seen low at a rising edge.
   // start stays high on exit so back-to-back requests need no gap.
   task automatic send_pixel(input uwr_req_type r, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Stops sending and waits for every pending write to come back.
   task automatic wait_for_drain();
      start = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      tracker.set_register(idx, value);
   endtask

   task automatic csr_read_check(input logic [2:0] idx);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== tracker.register_value(idx))
         tracker.report_mismatch($sformatf("register %0d reads %h, want %h",
                                           idx, csr_prdata, tracker.register_value(idx)));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // New frame/panel setup. Only done once the DUT has nothing in flight;
   // every request yields at least one write, so an empty pending list
   // means the pipeline is empty.
   task automatic apply_frame(input logic [31:0] fw, input logic [31:0] fh,
                              input logic [31:0] pw, input logic [31:0] ph,
                              input logic [31:0] pitch, input logic [31:0] bgra);
      int i;
      wait_for_drain();
      repeat (8) @(negedge clock);
      csr_write(REG_FRAME_WIDTH,  fw);
      csr_write(REG_FRAME_HEIGHT, fh);
      csr_write(REG_PANEL_WIDTH,  pw);
      csr_write(REG_PANEL_HEIGHT, ph);
      csr_write(REG_PITCH_WORDS,  pitch);
      csr_write(REG_ORDER_BGRA,   bgra);
      for (i = 0; i <= int'(REG_ORDER_BGRA); i++)
         csr_read_check(3'(i));
   endtask

   // Mostly setups that give a real scale (1..8, plus some that would
   // exceed the cap), the rest raw register noise that mostly faults.
   task automatic random_frame();
      int s, fw, fh, pw, ph, pitch;
      bit wide;
      if ($urandom_range(9) < 7) begin
         s    = $urandom_range(1, 9);
         wide = ($urandom_range(3) == 0);
         fw   = $urandom_range(1, wide ? MAX_DIM / s : 24);
         fh   = $urandom_range(1, wide ? MAX_DIM / s : 24);
         pw   = fw * s + $urandom_range(0, fw - 1);
         ph   = fh * s + $urandom_range(0, 2 * fh);
         if (pw > MAX_DIM) pw = MAX_DIM;
         if (ph > MAX_DIM) ph = MAX_DIM;
         pitch = $urandom_range(1) ? $urandom_range(pw, 16383) : $urandom_range(16383);
         apply_frame(fw, fh, pw, ph, pitch, $urandom_range(1));
      end else begin
         apply_frame($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // Coordinates mostly land inside the current frame; the rest are any
   // 12-bit value so every coordinate bit toggles.
   function automatic uwr_req_type random_pixel();
      int fw, fh;
      logic [11:0] col, row;
      fw = tracker.cfg.frame_width;
      fh = tracker.cfg.frame_height;
      if (fw != 0 && fw <= MAX_DIM && $urandom_range(99) < 85)
         col = $urandom_range(fw - 1);
      else
         col = $urandom;
      if (fh != 0 && fh <= MAX_DIM && $urandom_range(99) < 85)
         row = $urandom_range(fh - 1);
      else
         row = $urandom;
      return make_req($urandom, col, row);
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int phase, n, idle_pct;
      int sender_idle[4];
      sender_idle = '{0, 58, 0, 21};
      tracker     = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset setup: 1x1 frame on a 1x1 panel, scale 1, RGBA swap.
      send_pixel(make_req(32'hFFFF_FFFF, 12'd0, 12'd0), 0);
      send_pixel(make_req(32'h1234_5678, 12'd0, 12'd0), 0);
      send_pixel(make_req(32'h0000_0000, 12'd1, 12'd0), 0);      // column past frame
      send_pixel(make_req(32'h0000_0000, 12'd0, 12'd1), 0);      // row past frame
      send_pixel(make_req(32'hFFFF_FFFF, 12'hFFF, 12'hFFF), 0);

      // Fit factor 25 capped to 8, centered, BGRA kept as is.
      apply_frame(4, 3, 100, 90, 8192, 1);
      send_pixel(make_req(32'hA5C3_0F81, 12'd0, 12'd0), 0);
      send_pixel(make_req(32'hFFFF_FFFF, 12'd3, 12'd2), 0);
      send_pixel(make_req(32'h0000_0000, 12'd3, 12'd0), 0);
      send_pixel(make_req(32'h1234_5678, 12'd4, 12'd0), 0);
      send_pixel(make_req(32'h1234_5678, 12'd0, 12'd3), 0);

      // Exact fit at the cap, no centering offset needed in x.
      apply_frame(2, 2, 16, 17, 20, 0);
      send_pixel(make_req(32'h00FF_00FF, 12'd1, 12'd1), 0);

      // Largest frame, widest pitch: addresses wrap past 25 bits.
      apply_frame(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, 16383, 0);
      send_pixel(make_req(32'hDEAD_BEEF, 12'hFFF, 12'hFFF), 0);
      send_pixel(make_req(32'hCAFE_F00D, 12'd0, 12'hFFF), 0);
      send_pixel(make_req(32'h8001_7FFE, 12'hFFF, 12'd0), 0);

      // Zero pitch: every row lands on the same addresses.
      apply_frame(3, 2, 10, 7, 0, 1);
      send_pixel(make_req(32'h7F80_01FE, 12'd1, 12'd1), 0);

      // Fault setups: zero frame sizes, oversize frame, oversize panel,
      // frame larger than panel, zero panel.
      apply_frame(0, 5, 100, 100, 100, 0);
      send_pixel(make_req(32'h1111_1111, 12'd0, 12'd0), 0);
      apply_frame(5, 0, 100, 100, 100, 0);
      send_pixel(make_req(32'h2222_2222, 12'd0, 12'd0), 0);
      apply_frame(MAX_DIM + 1, 1, MAX_DIM, MAX_DIM, 100, 0);
      send_pixel(make_req(32'h3333_3333, 12'd0, 12'd0), 0);
      apply_frame(1, 1, 8191, 8191, 100, 0);
      send_pixel(make_req(32'h4444_4444, 12'd0, 12'd0), 0);
      apply_frame(100, 10, 99, MAX_DIM, 100, 1);
      send_pixel(make_req(32'h5555_5555, 12'd0, 12'd0), 0);
      apply_frame(1, 1, 0, 1, 100, 1);
      send_pixel(make_req(32'h6666_6666, 12'd0, 12'd0), 0);

      // Random part: new setup per phase, sender idle pattern rotates.
      // In the heavy-idle phases the sender also holds off now and then
      // until every pending write has come back.
      for (phase = 0; phase < 8; phase++) begin
         idle_pct = sender_idle[phase % 4];
         random_frame();
         for (n = 0; n < 32; n++) begin
            if (idle_pct == 58 && n % 8 == 7)
               wait_for_drain();
            send_pixel(random_pixel(), idle_pct);
         end
      end

      wait_for_drain();
      repeat (40) @(negedge clock);
      while (tracker.pending() != 0) begin
         tracker.report_mismatch("write never produced");
         void'(tracker.pending_writes.pop_front());
      end
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/uwr_pkg.sv
design/uwr_front.sv
design/uwr_queue.sv
design/uwr_back.sv
design/integer_upscale_center_writer_core.sv
dv/testbench.sv
